### rtl/asta_pkg.sv
// Shared widths, character codes, phase encoding and result type of the SGR attribute parser.
package asta_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned AttrW  = 8;
  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = 2;

  localparam logic [AttrW-1:0] AttrReset = 8'h07;

  localparam logic [CharW-1:0] ChEsc  = 16'h001B;
  localparam logic [CharW-1:0] ChLbr  = 16'h005B;
  localparam logic [CharW-1:0] ChSemi = 16'h003B;
  localparam logic [CharW-1:0] ChM    = 16'h006D;
  localparam logic [CharW-1:0] Ch0    = 16'h0030;
  localparam logic [CharW-1:0] Ch9    = 16'h0039;

  localparam logic KindChar = 1'b0;
  localparam logic KindAttr = 1'b1;

  typedef enum logic [2:0] {
    PhIdle   = 3'b001,
    PhEsc    = 3'b010,
    PhParams = 3'b100
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] out_char;
    logic [AttrW-1:0] attribute;
    logic             last;
  } res_t;

endpackage

### rtl/asta_in_if.sv
// Input channel: one UTF-16 code unit and its end-of-text flag per beat.
interface asta_in_if;
  logic                       valid;
  logic                       ready;
  logic [asta_pkg::CharW-1:0] char_code;
  logic                       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

### rtl/asta_out_if.sv
// Output channel: one display character or attribute change per beat.
interface asta_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [asta_pkg::CharW-1:0] out_char;
  logic [asta_pkg::AttrW-1:0] attribute;
  logic                       last;

  modport source (output valid, output kind, output out_char, output attribute, output last,
                  input ready);
  modport sink (input valid, input kind, input out_char, input attribute, input last,
                output ready);
endinterface

### rtl/ansi_sgr_to_text_attribute.sv
// SGR escape parser: turns a code unit stream into characters and text attribute changes.
//
//  channel             dir  beat contents
//  in_i                in   char_code, end_of_text
//  out_o               out  kind, out_char, attribute, last
//  default_attribute   in   write enable and 8-bit value, no read-back
//
// One input beat is taken per cycle while the three-entry result queue holds at most one
// result; the parser state updates on the accepting edge and its results are queued then.
// Results leave one per beat from the queue head, so an item with two results (a lone
// escape) leaves as two output beats. Reset clears the parser to idle, the attribute to 0x07
// and empties the queue. A stalled output drops in_i.ready once two results are queued.
module ansi_sgr_to_text_attribute (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   default_attribute_we_i,
  input  logic [asta_pkg::AttrW-1:0] default_attribute_i,
  asta_in_if.sink                in_i,
  asta_out_if.source             out_o
);
  import asta_pkg::*;

  phase_e           phase_q, phase_d;
  logic [AttrW-1:0] dflt_q;
  logic [AttrW-1:0] cur_q, cur_d;
  logic [AttrW-1:0] work_q, work_d;
  logic [AttrW-1:0] acc_q, acc_d;
  logic             dp_q, dp_d;
  logic [1:0]       bl_q, bl_d;
  logic             fz_q, fz_d;

  res_t             q_q [QDepth];
  res_t             q_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d;

  logic             in_fire, pop;
  logic [CharW-1:0] c;
  logic             eot, is_digit;
  logic [11:0]      mac;
  logic [AttrW-1:0] w_flush, nv;
  res_t             r0, r1;
  logic [1:0]       nres;
  logic [QCntW-1:0] base;

  function automatic logic [2:0] swap_rb(logic [2:0] v);
    return {v[0], v[1], v[2]};
  endfunction

  function automatic logic [AttrW-1:0] apply_param(logic [AttrW-1:0] n, logic [AttrW-1:0] w);
    logic [AttrW-1:0] r;
    logic [AttrW-1:0] o30, o40, o90;
    o30 = n - 8'd30;
    o40 = n - 8'd40;
    o90 = n - 8'd90;
    r = w;
    if (n < 8'd2) begin
      r = {w[7:4], n[0], w[2:0]};
    end else if (n >= 8'd30 && n < 8'd38) begin
      r = {w[7:3], swap_rb(o30[2:0])};
    end else if (n >= 8'd40 && n < 8'd48) begin
      r = {1'b0, swap_rb(o40[2:0]), w[3:0]};
    end else if (n >= 8'd90 && n < 8'd98) begin
      r = {w[7:4], 1'b1, swap_rb(o90[2:0])};
    end
    return r;
  endfunction

  assign in_i.ready = (cnt_q <= QCntW'(1));
  assign in_fire    = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;
  assign c          = in_i.char_code;
  assign eot        = in_i.end_of_text;
  assign is_digit   = (c >= Ch0) && (c <= Ch9);
  assign mac        = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {8'b0, c[3:0]};
  assign w_flush    = dp_q ? apply_param(acc_q, work_q) : work_q;
  assign nv         = (bl_q == 2'd1 && fz_q) ? dflt_q : w_flush;

  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    work_d  = work_q;
    acc_d   = acc_q;
    dp_d    = dp_q;
    bl_d    = bl_q;
    fz_d    = fz_q;
    r0      = '0;
    r1      = '0;
    nres    = 2'd0;
    case (phase_q)
      PhIdle: begin
        if (c == ChEsc && !eot) begin
          phase_d = PhEsc;
        end else begin
          r0.kind     = KindChar;
          r0.out_char = c;
          nres        = 2'd1;
        end
      end
      PhEsc: begin
        if (c == ChLbr) begin
          phase_d = PhIdle;
          if (!eot) begin
            work_d  = cur_q;
            acc_d   = '0;
            dp_d    = 1'b0;
            bl_d    = 2'd0;
            fz_d    = 1'b0;
            phase_d = PhParams;
          end
        end else begin
          r0.kind     = KindChar;
          r0.out_char = ChEsc;
          nres        = 2'd1;
          if (c == ChEsc && !eot) begin
            phase_d = PhEsc;
          end else begin
            r1.kind     = KindChar;
            r1.out_char = c;
            nres        = 2'd2;
            phase_d     = PhIdle;
          end
        end
      end
      PhParams: begin
        if (is_digit) begin
          acc_d = (mac > 12'd255) ? 8'hFF : mac[7:0];
          dp_d  = 1'b1;
          if (bl_q == 2'd0) fz_d = (c == Ch0);
          if (bl_q < 2'd2) bl_d = bl_q + 2'd1;
          if (eot) phase_d = PhIdle;
        end else if (c == ChSemi) begin
          work_d = w_flush;
          dp_d   = 1'b0;
          acc_d  = '0;
          if (bl_q < 2'd2) bl_d = bl_q + 2'd1;
          if (eot) phase_d = PhIdle;
        end else begin
          if (c == ChM) begin
            work_d = w_flush;
            dp_d   = 1'b0;
            acc_d  = '0;
            if (nv != cur_q) begin
              cur_d   = nv;
              r0.kind = KindAttr;
              nres    = 2'd1;
            end
          end
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    r0.attribute = cur_d;
    r1.attribute = cur_d;
    r0.last      = (nres == 2'd1);
    r1.last      = 1'b1;
  end

  // queue: shift on pop, then append this beat's results behind what remains
  always_comb begin
    base = cnt_q - QCntW'(pop);
    for (int i = 0; i < QDepth; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    cnt_d = base;
    if (in_fire) begin
      for (int i = 0; i < QDepth; i++) begin
        if (nres != 2'd0 && QCntW'(i) == base) q_d[i] = r0;
        if (nres == 2'd2 && QCntW'(i) == base + QCntW'(1)) q_d[i] = r1;
      end
      cnt_d = base + QCntW'(nres);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      dflt_q  <= AttrReset;
      cur_q   <= AttrReset;
      work_q  <= '0;
      acc_q   <= '0;
      dp_q    <= 1'b0;
      bl_q    <= 2'd0;
      fz_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (default_attribute_we_i) dflt_q <= default_attribute_i;
      if (in_fire) begin
        phase_q <= phase_d;
        cur_q   <= cur_d;
        work_q  <= work_d;
        acc_q   <= acc_d;
        dp_q    <= dp_d;
        bl_q    <= bl_d;
        fz_q    <= fz_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.kind      = q_q[0].kind;
  assign out_o.out_char  = q_q[0].out_char;
  assign out_o.attribute = q_q[0].attribute;
  assign out_o.last      = q_q[0].last;

  a_partner_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> (cnt_q >= QCntW'(2)))
    else $error("non-final result without its partner queued");

  a_attr_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KindAttr) |-> (out_o.out_char == '0 && out_o.last))
    else $error("attribute result carries a character or is not final");

  a_attr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(cur_q))
    else $error("attribute changed without an input beat");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == QCntW'(1) && !in_fire) |=> !out_o.valid)
    else $error("result appeared from an empty queue");

endmodule

### tb/asta_tb_pkg.sv
// Scoreboard class that predicts and checks the results of the SGR attribute parser.
package asta_tb_pkg;
  import asta_pkg::*;

  class sgr_scoreboard;
    res_t             pending_results[$];
    int unsigned      mismatches;
    logic [AttrW-1:0] default_attr;
    phase_e           phase;
    logic [AttrW-1:0] cur_attr;
    logic [AttrW-1:0] work_attr;
    logic [7:0]       accum;
    bit               has_digits;
    logic [1:0]       body_len;
    bit               lead_zero;

    function new();
      mismatches   = 0;
      default_attr = AttrReset;
      phase        = PhIdle;
      cur_attr     = AttrReset;
      work_attr    = '0;
      accum        = '0;
      has_digits   = 1'b0;
      body_len     = '0;
      lead_zero    = 1'b0;
    endfunction

    function void set_default(logic [AttrW-1:0] value);
      default_attr = value;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function logic [2:0] colour(int unsigned n);
      int unsigned d;
      d = n % 10;
      return {d[0], d[1], d[2]};
    endfunction

    function void apply_number(int unsigned n);
      logic [2:0] col;
      col = colour(n);
      if (n < 2) begin
        work_attr[3] = (n != 0);
      end else if (n >= 30 && n < 38) begin
        work_attr[2:0] = col;
      end else if (n >= 40 && n < 48) begin
        work_attr[7:4] = {1'b0, col};
      end else if (n >= 90 && n < 98) begin
        work_attr[3:0] = {1'b1, col};
      end
    endfunction

    function void close_number();
      if (has_digits) begin
        apply_number(accum);
      end
      has_digits = 1'b0;
      accum      = '0;
    endfunction

    function res_t make_res(logic kind, logic [CharW-1:0] ch);
      res_t r;
      r.kind      = kind;
      r.out_char  = ch;
      r.attribute = cur_attr;
      r.last      = 1'b0;
      return r;
    endfunction

    function void take_unit(logic [CharW-1:0] c, logic eot);
      res_t             batch[2];
      int               n;
      int unsigned      v;
      logic [AttrW-1:0] nv;
      n = 0;
      case (phase)
        PhEsc: begin
          if (c == ChLbr) begin
            phase = PhIdle;
            if (!eot) begin
              work_attr  = cur_attr;
              accum      = '0;
              has_digits = 1'b0;
              body_len   = '0;
              lead_zero  = 1'b0;
              phase      = PhParams;
            end
          end else begin
            batch[n] = make_res(KindChar, ChEsc);
            n++;
            if (c == ChEsc && !eot) begin
              phase = PhEsc;
            end else begin
              batch[n] = make_res(KindChar, c);
              n++;
              phase = PhIdle;
            end
          end
        end
        PhParams: begin
          if (c >= Ch0 && c <= Ch9) begin
            v          = int'(accum) * 10 + int'(c - Ch0);
            accum      = (v > 255) ? 8'hFF : v[7:0];
            has_digits = 1'b1;
            if (body_len == 0) begin
              lead_zero = (c == Ch0);
            end
            if (body_len < 2) begin
              body_len++;
            end
            if (eot) begin
              phase = PhIdle;
            end
          end else if (c == ChSemi) begin
            close_number();
            if (body_len < 2) begin
              body_len++;
            end
            if (eot) begin
              phase = PhIdle;
            end
          end else begin
            if (c == ChM) begin
              close_number();
              nv = (body_len == 1 && lead_zero) ? default_attr : work_attr;
              if (nv != cur_attr) begin
                cur_attr = nv;
                batch[n] = make_res(KindAttr, '0);
                n++;
              end
            end
            phase = PhIdle;
          end
        end
        default: begin
          phase = PhIdle;
          if (c == ChEsc && !eot) begin
            phase = PhEsc;
          end else begin
            batch[n] = make_res(KindChar, c);
            n++;
          end
        end
      endcase
      if (n > 0) begin
        batch[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        pending_results.push_back(batch[i]);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: kind=%0d char=%h attr=%h last=%0d",
                   got.kind, got.out_char, got.attribute, got.last);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.out_char !== want.out_char ||
          got.attribute !== want.attribute || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected kind=%0d char=%h attr=%h last=%0d, got kind=%0d char=%h attr=%h last=%0d",
                   want.kind, want.out_char, want.attribute, want.last,
                   got.kind, got.out_char, got.attribute, got.last);
        end
      end
    endfunction
  endclass

endpackage

### tb/ansi_sgr_to_text_attribute_tb.sv
// Top-level testbench of the SGR attribute parser: directed and random text with checked beats.
module ansi_sgr_to_text_attribute_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asta_pkg::*;
  import asta_tb_pkg::*;

  typedef enum int unsigned {RxOpen, RxCoin, RxThird, RxLong} rx_mode_e;

  logic             clk = 1'b0;
  logic             rst_ni;
  logic             default_attribute_we;
  logic [AttrW-1:0] default_attribute;
  int unsigned      burst_left;
  int unsigned      units_sent;
  res_t             seen;
  sgr_scoreboard    sb;

  asta_in_if  in_if ();
  asta_out_if out_if ();

  ansi_sgr_to_text_attribute uut (
    .clk_i                 (clk),
    .rst_ni                (rst_ni),
    .default_attribute_we_i(default_attribute_we),
    .default_attribute_i   (default_attribute),
    .in_i                  (in_if),
    .out_o                 (out_if)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen = {out_if.kind, out_if.out_char, out_if.attribute, out_if.last};
      sb.check_result(seen);
    end
  end

  initial begin
    rx_mode_e    mode;
    int unsigned left;
    int unsigned tick;
    out_if.ready = 1'b0;
    mode = RxOpen;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(8, 80);
      end
      left--;
      tick++;
      case (mode)
        RxOpen:  out_if.ready = 1'b1;
        RxCoin:  out_if.ready = 1'($urandom_range(0, 1));
        RxThird: out_if.ready = (tick % 3) != 0;
        default: out_if.ready = (tick % 24) >= 18;
      endcase
    end
  end

  function automatic logic rare_eot();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic send_unit(logic [CharW-1:0] c, logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid       = 1'b1;
    in_if.char_code   = c;
    in_if.end_of_text = eot;
    do @(posedge clk); while (!in_if.ready);
    sb.take_unit(c, eot);
    units_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic eot_end);
    for (int i = 0; i < s.len(); i++) begin
      send_unit({8'h00, s[i]}, eot_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_number(int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) begin
      send_unit({8'h00, s[i]}, rare_eot());
    end
  endtask

  task automatic send_sgr();
    int unsigned count;
    int unsigned pick;
    send_unit(ChEsc, 1'b0);
    send_unit(ChLbr, rare_eot());
    count = $urandom_range(0, 4);
    if ($urandom_range(0, 7) == 0) begin
      send_unit(Ch0, rare_eot());
    end else begin
      for (int i = 0; i < count; i++) begin
        if (i > 0) begin
          send_unit(ChSemi, rare_eot());
        end
        pick = $urandom_range(0, 9);
        case (pick)
          0: ;
          1: send_number($urandom_range(0, 1));
          2, 3: send_number(30 + $urandom_range(0, 7));
          4: send_number(40 + $urandom_range(0, 7));
          5: send_number(90 + $urandom_range(0, 7));
          6: send_number($urandom_range(0, 999));
          7: begin
            send_unit(Ch0, rare_eot());
            send_number($urandom_range(0, 99));
          end
          default: send_number($urandom_range(2, 99));
        endcase
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      send_unit(ChM, rare_eot());
    end else begin
      send_unit(CharW'($urandom_range(16'h20, 16'h7E)), rare_eot());
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 5))
      0: begin
        repeat ($urandom_range(1, 6)) begin
          send_unit(CharW'($urandom_range(0, 65535)), $urandom_range(0, 15) == 0);
        end
      end
      1: send_unit(CharW'($urandom_range(16'h20, 16'h7E)), rare_eot());
      2: begin
        send_unit(ChEsc, $urandom_range(0, 3) == 0);
        send_unit(CharW'($urandom_range(0, 65535)), rare_eot());
      end
      3: begin
        send_unit(ChEsc, 1'b0);
        send_unit(ChEsc, 1'($urandom_range(0, 1)));
        send_unit(CharW'($urandom_range(16'h20, 16'h7E)), rare_eot());
      end
      4: begin
        send_unit(ChEsc, 1'b0);
        send_unit(ChLbr, 1'b0);
        send_number($urandom_range(0, 99));
        send_unit($urandom_range(0, 1) ? ChSemi : Ch9, 1'b1);
      end
      default: send_unit(CharW'($urandom_range(0, 65535)), 1'b0);
    endcase
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_default(logic [AttrW-1:0] value);
    default_attribute_we = 1'b1;
    default_attribute    = value;
    @(negedge clk);
    default_attribute_we = 1'b0;
    sb.set_default(value);
  endtask

  initial begin
    int unsigned target;
    logic [AttrW-1:0] setting;
    sb                   = new();
    rst_ni               = 1'b0;
    default_attribute_we = 1'b0;
    default_attribute    = '0;
    in_if.valid          = 1'b0;
    in_if.char_code      = '0;
    in_if.end_of_text    = 1'b0;
    burst_left           = 0;
    units_sent           = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    write_default(8'hC3);
    send_unit(16'h0000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_text("\033[1;42m", 1'b0);
    send_text("\033[;95m", 1'b0);
    send_text("\033[0m", 1'b0);
    send_text("\033A", 1'b0);
    send_text("\033\033", 1'b1);
    send_text("\033", 1'b1);
    send_text("\033[", 1'b1);
    send_text("\033[9x", 1'b0);
    send_text("\033[m", 1'b0);

    for (int p = 0; p < 4; p++) begin
      drain();
      setting = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      write_default(setting);
      target = units_sent + 250;
      while (units_sent < target) begin
        if ($urandom_range(0, 9) < 6) begin
          send_sgr();
        end else begin
          send_noise();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
